/* rtl/ubof_pkg.sv */
`timescale 1ns / 1ps

package ubof_pkg;

   // Descriptor constants
   localparam logic [7:0] PRINTER_CLASS  = 8'h07;
   localparam logic [7:0] DIR_IN_BIT     = 8'h80;
   localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
   localparam logic [7:0] XFER_TYPE_MASK = 8'h03;
   localparam logic [7:0] XFER_BULK      = 8'h02;
   localparam logic [7:0] TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
   localparam logic [7:0] MIN_DESC_LEN   = 8'h02;
   localparam logic [16:0] EP_DESC_SIZE  = 17'd7;
   localparam logic [15:0] MIN_BUFFER    = 16'd9;
   localparam logic [15:0] CONFIG_POS    = 16'd5;

   // Offsets inside one descriptor
   localparam logic [15:0] REL_LENGTH    = 16'd0;
   localparam logic [15:0] REL_TYPE      = 16'd1;
   localparam logic [15:0] REL_ADDRESS   = 16'd2;
   localparam logic [15:0] REL_ATTRIB    = 16'd3;
   localparam logic [15:0] REL_NUM_EP    = 16'd4;
   localparam logic [15:0] REL_CLASS     = 16'd5;

   // CSR map: register index is paddr[2]
   localparam logic        REG_BUFFER_LENGTH   = 1'b0;
   localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd256;

   // One parser decision
   typedef struct packed {
      logic       emit;
      logic       found;
      logic [3:0] endpoint_number;
      logic [7:0] configuration_value;
   } result_type;

endpackage

/* rtl/ubof_parser.sv */
`timescale 1ns / 1ps

module ubof_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                start_of_buffer,
   input  logic [15:0]         buffer_length,
   output ubof_pkg::result_type result
);
   import ubof_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  left_ff, left_in;
   logic        win_ff, win_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  cfg_ff, cfg_in;
   logic        dec_ff, dec_in;

   // working copies after the optional restart
   logic [15:0] cur_pos, cur_start, rel;
   logic [7:0]  cur_len, cur_left, cur_count, cur_type, cur_addr, cur_cfg;
   logic        cur_win, active, new_desc, short_buf, bad_len, match, at_end;
   logic [16:0] desc_end;

   always_comb begin
      if (start_of_buffer) begin
         cur_pos   = '0;
         cur_start = '0;
         cur_len   = '0;
         cur_type  = '0;
         cur_count = '0;
         cur_left  = '0;
         cur_win   = 1'b0;
         cur_addr  = '0;
         cur_cfg   = '0;
      end else begin
         cur_pos   = pos_ff + 16'd1;
         cur_start = start_ff;
         cur_len   = len_ff;
         cur_type  = type_ff;
         cur_count = count_ff;
         cur_left  = left_ff;
         cur_win   = win_ff;
         cur_addr  = addr_ff;
         cur_cfg   = cfg_ff;
      end
      active    = step && (start_of_buffer || !dec_ff);
      short_buf = start_of_buffer && (buffer_length < MIN_BUFFER);

      desc_end = {1'b0, cur_start} + {9'd0, cur_len};
      new_desc = ({1'b0, cur_pos} == desc_end);
      start_in = new_desc ? cur_pos : cur_start;
      win_in   = new_desc ? 1'b0 : cur_win;
      rel      = cur_pos - start_in;

      cfg_in   = (cur_pos == CONFIG_POS) ? data_byte : cur_cfg;
      len_in   = cur_len;
      type_in  = cur_type;
      addr_in  = cur_addr;
      count_in = cur_count;
      left_in  = cur_left;
      bad_len  = 1'b0;
      match    = 1'b0;

      case (rel)
         REL_LENGTH: begin
            len_in  = data_byte;
            type_in = '0;
            bad_len = (data_byte < MIN_DESC_LEN) ||
                      (({1'b0, start_in} + {9'd0, data_byte}) > {1'b0, buffer_length});
            if (cur_left != 8'd0) begin
               if (({1'b0, start_in} + EP_DESC_SIZE) <= {1'b0, buffer_length}) begin
                  win_in  = 1'b1;
                  left_in = cur_left - 8'd1;
               end else begin
                  left_in = '0;
               end
            end
         end
         REL_TYPE:    type_in = data_byte;
         REL_ADDRESS: addr_in = data_byte;
         REL_ATTRIB: begin
            match = cur_win && (cur_type == TYPE_ENDPOINT) &&
                    ((cur_addr & DIR_IN_BIT) == 8'd0) &&
                    ((data_byte & XFER_TYPE_MASK) == XFER_BULK);
         end
         REL_NUM_EP:  count_in = data_byte;
         REL_CLASS: begin
            if ((start_in != 16'd0) && (cur_type == TYPE_INTERFACE) &&
                (data_byte == PRINTER_CLASS) && (cur_count > cur_left))
               left_in = cur_count;
         end
         default: ;
      endcase

      at_end = ({1'b0, cur_pos} + 17'd1) >= {1'b0, buffer_length};
      pos_in = cur_pos;

      result.emit                = active && (short_buf || bad_len || match || at_end);
      result.found               = match && !short_buf;
      result.endpoint_number     = result.found ? (cur_addr[3:0] & EP_NUM_MASK[3:0]) : 4'd0;
      result.configuration_value = cfg_in;
      dec_in                     = result.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         win_ff   <= 1'b0;
         addr_ff  <= '0;
         cfg_ff   <= '0;
         dec_ff   <= 1'b1;
      end else if (active) begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         win_ff   <= win_in;
         addr_ff  <= addr_in;
         cfg_ff   <= cfg_in;
         dec_ff   <= dec_in;
      end
   end

`ifndef SYNTHESIS
   // a decision always parks the parser until the next start mark
   a_emit_parks: assert property (@(posedge clock) disable iff (reset)
      result.emit |=> dec_ff)
      else $error("parser not parked after a decision");

   // a match needs an open endpoint window inside the running buffer
   a_found_window: assert property (@(posedge clock) disable iff (reset)
      (result.emit && result.found) |-> (!start_of_buffer && win_ff))
      else $error("match outside an endpoint window");

   // without a start mark, a parked parser keeps its position
   a_parked_holds: assert property (@(posedge clock) disable iff (reset)
      (dec_ff && !(step && start_of_buffer)) |=> (dec_ff && $stable(pos_ff)))
      else $error("parked parser moved");
`endif

endmodule

/* rtl/usb_printer_bulk_out_finder.sv */
`timescale 1ns / 1ps

// Printer bulk OUT endpoint finder.
// req channel: one beat per configuration descriptor byte; req_start_of_buffer
// marks byte 0 and restarts parsing, dropping any buffer in progress.
// rsp channel: one beat per buffer, either found=1 with the endpoint number
// of the first printer bulk OUT endpoint, or found=0 (short buffer, bad
// descriptor length, or end of buffer reached). configuration_value carries
// byte 5 of the buffer, or 0 if the buffer ended before it.
// csr port: register 0 at byte address 0 is buffer_length (16 bits, reset
// 256). Write it only while no buffer is being parsed.
// Timing: one byte per cycle sustained while rsp is not stalled. A byte is
// registered in the input register on accept and parsed from there once
// the output slot is free; the decision is then registered onto rsp.
// Bytes after a decision are dropped silently.
// Stall: while a result waits on rsp_ready, one more byte is held in the
// input register and req_ready drops until the result leaves.
// Reset: parser parks until a start mark; both channels come up empty.
module usb_printer_bulk_out_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [3:0]  rsp_endpoint_number,
   output logic [7:0]  rsp_configuration_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ubof_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_sob_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff;
   logic [3:0]  ep_ff;
   logic [7:0]  cfg_ff;
   logic [15:0] blen_ff;
   logic        advance, req_beat, csr_write;
   result_type  result;

   // the input beat moves into the parser when the output slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      if (req_beat)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (advance && result.emit)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   ubof_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .data_byte       (in_byte_ff),
      .start_of_buffer (in_sob_ff),
      .buffer_length   (blen_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_data_byte;
         in_sob_ff  <= req_start_of_buffer;
      end
      if (advance && result.emit) begin
         found_ff <= result.found;
         ep_ff    <= result.endpoint_number;
         cfg_ff   <= result.configuration_value;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_found               = found_ff;
   assign rsp_endpoint_number     = ep_ff;
   assign rsp_configuration_value = cfg_ff;

   // CSR: access phase write, zero wait states
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         blen_ff <= BUFFER_LENGTH_RESET;
      else if (csr_write && (csr_paddr[2] == REG_BUFFER_LENGTH))
         blen_ff <= csr_pwdata[15:0];
   end

   assign csr_prdata = (csr_paddr[2] == REG_BUFFER_LENGTH) ? {16'd0, blen_ff} : 32'd0;

endmodule
